FILE: rtl/mec_pkg.sv
// Package for the Mandelbrot escape counter: widths, constants and the
// sequencer state type. No dependencies; every other file imports it.
package mec_pkg;

    localparam int COORD_W = 32;               // Q5.27 input coordinate
    localparam int Z_W     = COORD_W + 1;      // z grows past the input range
    localparam int PROD_W  = 2 * Z_W;          // exact signed product
    localparam int CNT_W   = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int FRAC_W  = 27;

    localparam logic [CNT_W-1:0]         MAX_ITER_RESET = 16'd256;
    // 4.0 in Q12.54, the squared-magnitude escape threshold.
    localparam logic signed [PROD_W-1:0] ESC_LIMIT      = PROD_W'(1) << (2 * FRAC_W + 2);
    // Largest magnitude of a z component that survived the escape test (2.0).
    localparam logic signed [Z_W-1:0]    Z_BOUND        = Z_W'(1) << (FRAC_W + 1);

    localparam logic [APB_AW-1:0] ADDR_MAX_ITER = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_TEST,
        S_UPD,
        S_DONE
    } t_state;

endpackage

FILE: rtl/mec_pt_if.sv
// Input channel of the escape counter: one complex point c per word.
// Depends on mec_pkg for the coordinate width.
interface mec_pt_if;
    import mec_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;

    modport source (output valid, output c_re, output c_im, input ready);
    modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

FILE: rtl/mec_cnt_if.sv
// Output channel of the escape counter: one escape count per word.
// Depends on mec_pkg for the count width.
interface mec_cnt_if;
    import mec_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] escape_count;

    modport source (output valid, output escape_count, input ready);
    modport sink   (input valid, input escape_count, output ready);
endinterface

FILE: rtl/mandelbrot_escape_counter_core.sv
// Mandelbrot escape-time counter: sequencer around one shared 33x33 multiplier.
// Depends on mec_pkg, mec_pt_if and mec_cnt_if.
//
// Usage:
//   i_pt takes one point c (c_re, c_im, signed Q5.27) per word; o_cnt gives one
//   escape_count per point. The APB port holds max_iterations (address 0,
//   reset 256); write it only while the block is idle.
//   Each escape step uses the shared multiplier in turn for re*re, im*im and,
//   together with the magnitude test, re*im, then does the z update. A point that
//   escapes or reaches max_iterations goes to the done state, and its word is
//   loaded into the output register from there. i_pt.ready is low for the whole
//   computation.
//   A finished count sits in the output register, so the next point is taken
//   while it waits. If the receiver still stalls when the next count is ready,
//   the sequencer holds that count until the output register frees.
//   Reset (i_rst_n low, synchronous) empties the output register, returns the
//   sequencer to idle and sets max_iterations back to 256.
module mandelbrot_escape_counter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mec_pt_if.sink                     i_pt,
    mec_cnt_if.source                  o_cnt,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mec_pkg::APB_AW-1:0] paddr,
    input  logic [mec_pkg::APB_DW-1:0] pwdata,
    output logic [mec_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import mec_pkg::*;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_max_iter;
    logic                       r_out_valid, n_out_valid;
    logic [CNT_W-1:0]           r_out_cnt, n_out_cnt;
    logic signed [Z_W-1:0]      r_re, n_re;
    logic signed [Z_W-1:0]      r_im, n_im;
    logic signed [COORD_W-1:0]  r_c_re, n_c_re;
    logic signed [COORD_W-1:0]  r_c_im, n_c_im;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic signed [PROD_W-1:0]   r_sq, n_sq;
    logic signed [PROD_W-1:0]   r_diff, n_diff;
    logic [CNT_W-1:0]           r_iter, n_iter;
    logic [CNT_W-1:0]           r_limit, n_limit;
    logic [CNT_W-1:0]           r_result, n_result;

    logic signed [Z_W-1:0]      w_op_a, w_op_b;
    logic signed [PROD_W-1:0]   w_mul;
    logic signed [PROD_W-1:0]   w_sum;
    logic signed [Z_W-1:0]      w_nre, w_nim;
    logic                       w_in_acc;
    logic                       w_cfg_wr;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_ITER);
    assign prdata   = (paddr == ADDR_MAX_ITER) ? APB_DW'(r_max_iter) : '0;

    // Shared multiplier and the arithmetic around it
    always_comb begin
        unique case (r_state)
            S_SQ_IM: begin
                w_op_a = r_im;
                w_op_b = r_im;
            end
            S_TEST: begin
                w_op_a = r_re;
                w_op_b = r_im;
            end
            default: begin
                w_op_a = r_re;
                w_op_b = r_re;
            end
        endcase
    end

    assign w_mul = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    assign w_sum = r_sq + r_prod;
    // Arithmetic right shifts round toward minus infinity.
    assign w_nre = Z_W'(r_diff >>> FRAC_W) + Z_W'(r_c_re);
    assign w_nim = Z_W'(r_prod >>> (FRAC_W - 1)) + Z_W'(r_c_im);

    assign i_pt.ready         = (r_state == S_IDLE);
    assign w_in_acc           = i_pt.valid && (r_state == S_IDLE);
    assign o_cnt.valid        = r_out_valid;
    assign o_cnt.escape_count = r_out_cnt;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_cnt.ready;
        n_out_cnt   = r_out_cnt;
        n_re        = r_re;
        n_im        = r_im;
        n_c_re      = r_c_re;
        n_c_im      = r_c_im;
        n_prod      = r_prod;
        n_sq        = r_sq;
        n_diff      = r_diff;
        n_iter      = r_iter;
        n_limit     = r_limit;
        n_result    = r_result;

        unique case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    n_re     = Z_W'(i_pt.c_re);
                    n_im     = Z_W'(i_pt.c_im);
                    n_c_re   = i_pt.c_re;
                    n_c_im   = i_pt.c_im;
                    n_iter   = '0;
                    n_limit  = r_max_iter;
                    n_result = '0;
                    n_state  = (r_max_iter == '0) ? S_DONE : S_SQ_RE;
                end
            end
            S_SQ_RE: begin
                n_prod  = w_mul;
                n_state = S_SQ_IM;
            end
            S_SQ_IM: begin
                n_sq    = r_prod;
                n_prod  = w_mul;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (w_sum > ESC_LIMIT) begin
                    n_result = r_iter;
                    n_state  = S_DONE;
                end else begin
                    n_diff  = r_sq - r_prod;
                    n_prod  = w_mul;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_re = w_nre;
                n_im = w_nim;
                if (r_iter + CNT_W'(1) == r_limit) begin
                    n_result = r_limit;
                    n_state  = S_DONE;
                end else begin
                    n_iter  = r_iter + CNT_W'(1);
                    n_state = S_SQ_RE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_cnt.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_iter  <= MAX_ITER_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_max_iter <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cnt <= n_out_cnt;
        r_re      <= n_re;
        r_im      <= n_im;
        r_c_re    <= n_c_re;
        r_c_im    <= n_c_im;
        r_prod    <= n_prod;
        r_sq      <= n_sq;
        r_diff    <= n_diff;
        r_iter    <= n_iter;
        r_limit   <= n_limit;
        r_result  <= n_result;
    end

    // The step counter stays below the limit captured with the point.
    a_iter_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ_RE || r_state == S_SQ_IM || r_state == S_TEST ||
         r_state == S_UPD) |-> (r_iter < r_limit))
        else $error("step counter reached the iteration limit while busy");

    // A count never exceeds the limit that produced it.
    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_result <= r_limit))
        else $error("escape count above the iteration limit");

    // Only a z that passed the magnitude test is updated.
    a_update_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_re <= Z_BOUND && r_re >= -Z_BOUND &&
                                r_im <= Z_BOUND && r_im >= -Z_BOUND))
        else $error("z update taken on an escaped point");

    // An accepted point starts the square sequence or finishes at once.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SQ_RE || r_state == S_DONE))
        else $error("accepted point did not start the sequencer");

endmodule
